>>> hw/rtl/ladder_switch_debounce_classifier_macros.svh
// Assertion macros for the ladder switch debounce classifier.
`ifndef LADDER_SWITCH_DEBOUNCE_CLASSIFIER_MACROS_SVH
`define LADDER_SWITCH_DEBOUNCE_CLASSIFIER_MACROS_SVH

`ifndef SYNTH
`define LSDC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsdc assertion failed");
`define LSDC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsdc assertion failed");
`else
`define LSDC_ASSERT_IMP(name, ante, cons)
`define LSDC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> hw/rtl/lsdc_pkg.sv
// Shared types and codes for the ladder switch debounce classifier.
package lsdc_pkg;

  typedef enum logic [2:0] {
    CL_UNKNOWN = 3'd0,
    CL_OFF     = 3'd1,
    CL_AUTO    = 3'd2,
    CL_MANUAL  = 3'd3,
    CL_DISC    = 3'd4,
    CL_BUTTON  = 3'd5,
    CL_INVALID = 3'd6
  } class_t;

  typedef enum logic [2:0] {
    MODE_UNKNOWN = 3'd0,
    MODE_OFF     = 3'd1,
    MODE_AUTO    = 3'd2,
    MODE_MANUAL  = 3'd3,
    MODE_DISC    = 3'd4,
    MODE_INVALID = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    BTN_UNKNOWN  = 2'd0,
    BTN_RELEASED = 2'd1,
    BTN_SHORT    = 2'd2,
    BTN_LONG     = 2'd3
  } button_t;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_OFF    = 3'd1;
  localparam logic [2:0] EV_AUTO   = 3'd2;
  localparam logic [2:0] EV_MANUAL = 3'd3;

  localparam logic [2:0] SYS_INACTIVE = 3'd0;
  localparam logic [2:0] SYS_ACC_ON   = 3'd1;
  localparam logic [2:0] SYS_PRE_OFF  = 3'd2;
  localparam logic [2:0] SYS_ACTIVE   = 3'd3;
  localparam logic [2:0] SYS_INSPECT  = 3'd4;

  typedef struct packed {
    logic [2:0]  system_state;
    logic        sample_valid;
    logic [9:0]  ladder_sample;
    logic [15:0] time_now;
  } in_item_t;

  typedef struct packed {
    mode_t      switch_mode;
    button_t    button_state;
    logic [7:0] press_change_count;
    logic       module_ok_event;
    logic [2:0] mode_event;
  } out_item_t;

  // Per-request control toward the agreement stage.
  typedef struct packed {
    logic clear;
    logic judge;
    logic sample_valid;
  } agree_ctl_t;

  // Per-request control toward the mode tracker.
  typedef struct packed {
    logic   clear;
    logic   fire;
    class_t cls;
  } confirm_t;

endpackage

>>> hw/rtl/lsdc_classify.sv
// Window classifier for the resistor ladder sample.
module lsdc_classify
  import lsdc_pkg::*;
(
  input  logic [9:0] ladder_sample,
  output class_t     cls
);

  localparam logic [9:0] BUTTON_HI = 10'd40;
  localparam logic [9:0] OFF_LO    = 10'd368;
  localparam logic [9:0] OFF_HI    = 10'd450;
  localparam logic [9:0] MANUAL_LO = 10'd573;
  localparam logic [9:0] MANUAL_HI = 10'd655;
  localparam logic [9:0] AUTO_LO   = 10'd778;
  localparam logic [9:0] AUTO_HI   = 10'd860;
  localparam logic [9:0] DISC_LO   = 10'd982;

  always_comb begin
    if (ladder_sample <= BUTTON_HI) begin
      cls = CL_BUTTON;
    end else if (ladder_sample >= OFF_LO && ladder_sample <= OFF_HI) begin
      cls = CL_OFF;
    end else if (ladder_sample >= MANUAL_LO && ladder_sample <= MANUAL_HI) begin
      cls = CL_MANUAL;
    end else if (ladder_sample >= AUTO_LO && ladder_sample <= AUTO_HI) begin
      cls = CL_AUTO;
    end else if (ladder_sample >= DISC_LO) begin
      cls = CL_DISC;
    end else begin
      cls = CL_INVALID;
    end
  end

endmodule

>>> hw/rtl/lsdc_agree.sv
// Class history and run counter that confirm a class after equal reads.
module lsdc_agree
  import lsdc_pkg::*;
#(
  parameter int AGREE_DEPTH = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  agree_ctl_t ctl,
  input  class_t     cls,
  output logic       confirm
);

  localparam int RC_W = $clog2(AGREE_DEPTH + 1);
  localparam logic [RC_W-1:0] RC_FULL = RC_W'(AGREE_DEPTH);

  // Entry zero always equals the newest class, so only older entries are kept.
  class_t          hist      [1:AGREE_DEPTH-1];
  class_t          hist_cur  [1:AGREE_DEPTH-1];
  class_t          hist_next [1:AGREE_DEPTH-1];
  logic [RC_W-1:0] run_count;
  logic [RC_W-1:0] rc_cur;
  logic [RC_W-1:0] rc_bump;
  logic [RC_W-1:0] run_count_next;
  logic            same;

  always_comb begin
    for (int k = 1; k < AGREE_DEPTH; k++) begin
      hist_cur[k] = ctl.clear ? CL_UNKNOWN : hist[k];
    end
    rc_cur  = ctl.clear ? '0 : run_count;
    rc_bump = (rc_cur < RC_FULL) ? rc_cur + RC_W'(1) : rc_cur;
    same    = (rc_bump == RC_FULL);
    for (int k = 1; k < AGREE_DEPTH; k++) begin
      if (hist_cur[k] != cls) begin
        same = 1'b0;
      end
    end

    hist_next      = hist_cur;
    run_count_next = rc_cur;
    confirm        = 1'b0;
    if (ctl.judge) begin
      if (!ctl.sample_valid) begin
        run_count_next = '0;
      end else if (same) begin
        run_count_next = '0;
        confirm        = 1'b1;
      end else begin
        run_count_next = rc_bump;
        // Shift in the new class as far as the run has filled.
        hist_next[1] = cls;
        for (int k = 2; k < AGREE_DEPTH; k++) begin
          if (rc_bump >= RC_W'(k)) begin
            hist_next[k] = hist_cur[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
      for (int k = 1; k < AGREE_DEPTH; k++) begin
        hist[k] <= CL_UNKNOWN;
      end
    end else begin
      run_count <= run_count_next;
      hist      <= hist_next;
    end
  end

endmodule

>>> hw/rtl/lsdc_mode.sv
// Held mode, record button tracking and event generation.
module lsdc_mode
  import lsdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  confirm_t    conf,
  input  logic [15:0] time_now,
  input  logic [15:0] long_press_time,
  output out_item_t   result
);

  mode_t       held_mode, held_cur, held_next, m;
  button_t     button_phase, phase_cur, phase_next;
  logic [15:0] press_start, ps_cur, ps_next, elapsed;
  logic [7:0]  change_counter, cnt_cur, cnt_next;
  logic        first_event_pending, fep_cur, fep_next;
  logic        mok;
  logic [2:0]  ev;

  always_comb begin
    held_cur  = conf.clear ? MODE_UNKNOWN : held_mode;
    phase_cur = conf.clear ? BTN_UNKNOWN : button_phase;
    ps_cur    = conf.clear ? 16'd0 : press_start;
    cnt_cur   = conf.clear ? 8'd0 : change_counter;
    fep_cur   = conf.clear ? 1'b1 : first_event_pending;

    held_next  = held_cur;
    phase_next = phase_cur;
    ps_next    = ps_cur;
    cnt_next   = cnt_cur;
    fep_next   = fep_cur;
    m          = held_cur;
    mok        = 1'b0;
    ev         = EV_NONE;
    elapsed    = time_now - ps_cur;

    if (conf.fire) begin
      if (conf.cls == CL_BUTTON) begin
        case (phase_cur)
          BTN_RELEASED: begin
            phase_next = BTN_SHORT;
            ps_next    = time_now;
            cnt_next   = cnt_cur + 8'd1;
          end
          BTN_SHORT: begin
            if (elapsed >= long_press_time) begin
              phase_next = BTN_LONG;
              ps_next    = 16'd0;
            end
          end
          default: begin
          end
        endcase
      end else begin
        case (conf.cls)
          CL_OFF:    m = MODE_OFF;
          CL_AUTO:   m = MODE_AUTO;
          CL_MANUAL: m = MODE_MANUAL;
          CL_DISC:   m = MODE_DISC;
          default:   m = MODE_INVALID;
        endcase
        if (phase_cur != BTN_RELEASED) begin
          cnt_next = cnt_cur + 8'd1;
        end
        phase_next = BTN_RELEASED;
        ps_next    = 16'd0;
      end

      if (m != held_cur) begin
        // Invalid mode is held silently.
        if (m != MODE_UNKNOWN && m != MODE_INVALID) begin
          if (fep_cur) begin
            fep_next = 1'b0;
            mok      = (m != MODE_DISC);
          end
          ev = m;
        end
        held_next = m;
      end
    end

    result.switch_mode        = held_next;
    result.button_state       = phase_next;
    result.press_change_count = cnt_next;
    result.module_ok_event    = mok;
    result.mode_event         = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mode           <= MODE_UNKNOWN;
      button_phase        <= BTN_UNKNOWN;
      press_start         <= 16'd0;
      change_counter      <= 8'd0;
      first_event_pending <= 1'b1;
    end else begin
      held_mode           <= held_next;
      button_phase        <= phase_next;
      press_start         <= ps_next;
      change_counter      <= cnt_next;
      first_event_pending <= fep_next;
    end
  end

endmodule

>>> hw/rtl/ladder_switch_debounce_classifier.sv
// Top level of the ladder switch debounce classifier.
// A request passes from the input register through classify/agree/mode to the result register.
// Throughput: one request per cycle while the result register is not stalled.
// A stalled result holds the input register, so intake stalls once both registers are full.
// Reset (rst, synchronous) clears all tracking state and sets long_press_time to 300.
// The configuration channel is always ready.
module ladder_switch_debounce_classifier
  import lsdc_pkg::*;
#(
  parameter int AGREE_DEPTH = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  `include "ladder_switch_debounce_classifier_macros.svh"

  localparam logic [15:0] LONG_PRESS_RESET = 16'd300;

  in_item_t    s1_data;
  logic        s1_valid;
  logic        adv;
  logic        active;
  logic        prev_was_pre_off;
  logic [15:0] long_press_time;
  class_t      cls;
  logic        confirm;
  agree_ctl_t  agree_ctl;
  confirm_t    conf;
  out_item_t   result;
  logic        ev_seen;
  logic        ev_is_mode;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;

  assign active = (s1_data.system_state == SYS_ACC_ON) ||
                  (s1_data.system_state == SYS_PRE_OFF) ||
                  (s1_data.system_state == SYS_ACTIVE) ||
                  (s1_data.system_state == SYS_INSPECT);

  always_comb begin
    agree_ctl.clear        = adv && prev_was_pre_off && (s1_data.system_state == SYS_ACC_ON);
    agree_ctl.judge        = adv && active && (s1_data.system_state != SYS_INSPECT);
    agree_ctl.sample_valid = s1_data.sample_valid;
    conf.clear             = agree_ctl.clear;
    conf.fire              = confirm;
    conf.cls               = cls;
  end

  lsdc_classify u_classify (
    .ladder_sample (s1_data.ladder_sample),
    .cls           (cls)
  );

  lsdc_agree #(
    .AGREE_DEPTH (AGREE_DEPTH)
  ) u_agree (
    .clk     (clk),
    .rst     (rst),
    .ctl     (agree_ctl),
    .cls     (cls),
    .confirm (confirm)
  );

  lsdc_mode u_mode (
    .clk             (clk),
    .rst             (rst),
    .conf            (conf),
    .time_now        (s1_data.time_now),
    .long_press_time (long_press_time),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      long_press_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_pre_off <= 1'b0;
    end else if (adv && active) begin
      prev_was_pre_off <= (s1_data.system_state == SYS_PRE_OFF);
    end
  end

  // Input register: load on accept, drop when the request moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

  assign ev_seen    = out_valid && (out_data.mode_event != EV_NONE);
  assign ev_is_mode = (out_data.mode_event == EV_OFF) || (out_data.mode_event == EV_AUTO) ||
                      (out_data.mode_event == EV_MANUAL);

  `LSDC_ASSERT_IMP(a_event_matches_mode, ev_seen, out_data.mode_event == out_data.switch_mode)
  `LSDC_ASSERT_IMP(a_ok_only_on_mode, out_valid && out_data.module_ok_event, ev_is_mode)
  `LSDC_ASSERT_NEXT(a_advance_fills_output, adv, out_valid)

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the ladder switch debounce classifier.
`timescale 1ns / 100ps

module testbench;
  import lsdc_pkg::*;

  localparam int AGREE_DEPTH = 5;
  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 7;
  localparam int LONG_HOLD = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 310;
  localparam logic [2:0] SYS_UNDEF = 3'd7;
  localparam logic [15:0] RESET_HOLD_LIMIT = 16'd300;
  localparam out_item_t RESET_REPORT = '{MODE_UNKNOWN, BTN_UNKNOWN, 8'd0, 1'b0, EV_NONE};

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the switch tracking state.
  class_t      hist [AGREE_DEPTH];
  int          run_len;
  mode_t       held;
  button_t     btn;
  logic [15:0] press_t0;
  logic [7:0]  changes;
  bit          first_pending;
  bit          prev_pre_off;
  logic [15:0] hold_limit;

  out_item_t   expected_reports [$];
  out_item_t   head_report;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic [15:0] tick_clock = '0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          long_hold_busy = 1'b0;

  ladder_switch_debounce_classifier #(
    .AGREE_DEPTH(AGREE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_tracking();
    for (int k = 0; k < AGREE_DEPTH; k++) hist[k] = CL_UNKNOWN;
    run_len = 0;
    held = MODE_UNKNOWN;
    btn = BTN_UNKNOWN;
    press_t0 = '0;
    changes = '0;
    first_pending = 1'b1;
    prev_pre_off = 1'b0;
  endfunction

  function automatic class_t ladder_window(logic [9:0] v);
    if (v <= 10'd40) return CL_BUTTON;
    if (v < 10'd368) return CL_INVALID;
    if (v <= 10'd450) return CL_OFF;
    if (v < 10'd573) return CL_INVALID;
    if (v <= 10'd655) return CL_MANUAL;
    if (v < 10'd778) return CL_INVALID;
    if (v <= 10'd860) return CL_AUTO;
    if (v < 10'd982) return CL_INVALID;
    return CL_DISC;
  endfunction

  // Advance the tracking state by one request and return the report it yields.
  function automatic out_item_t predict_switch_report(in_item_t it);
    out_item_t   r;
    bit          agreed;
    class_t      c;
    mode_t       m;
    logic [15:0] elapsed;
    logic        mok;
    logic [2:0]  ev;
    mok = 1'b0;
    ev = EV_NONE;
    agreed = 1'b0;
    if (it.system_state >= SYS_ACC_ON && it.system_state <= SYS_INSPECT) begin
      if (prev_pre_off && it.system_state == SYS_ACC_ON) clear_tracking();
      prev_pre_off = (it.system_state == SYS_PRE_OFF);
      if (it.system_state != SYS_INSPECT) begin
        if (!it.sample_valid) begin
          run_len = 0;
        end else begin
          hist[0] = ladder_window(it.ladder_sample);
          if (run_len < AGREE_DEPTH) run_len++;
          if (run_len >= AGREE_DEPTH) begin
            agreed = 1'b1;
            for (int k = 0; k < AGREE_DEPTH - 1; k++)
              if (hist[k] != hist[k + 1]) agreed = 1'b0;
            if (agreed) run_len = 0;
          end
          // Shift the history only while no class is confirmed.
          if (!agreed)
            for (int k = run_len; k > 0; k--)
              if (k < AGREE_DEPTH) hist[k] = hist[k - 1];
        end
        if (agreed) begin
          c = hist[0];
          if (c == CL_BUTTON) begin
            m = held;
            if (btn == BTN_RELEASED) begin
              btn = BTN_SHORT;
              press_t0 = it.time_now;
              changes++;
            end else if (btn == BTN_SHORT) begin
              elapsed = it.time_now - press_t0;
              if (elapsed >= hold_limit) begin
                btn = BTN_LONG;
                press_t0 = '0;
              end
            end
          end else begin
            m = (c == CL_INVALID) ? MODE_INVALID : mode_t'(c);
            if (btn != BTN_RELEASED) changes++;
            btn = BTN_RELEASED;
            press_t0 = '0;
          end
          if (m != held) begin
            if (m >= MODE_OFF && m <= MODE_DISC) begin
              if (first_pending) begin
                first_pending = 1'b0;
                if (m <= MODE_MANUAL) mok = 1'b1;
              end
              ev = m;
            end
            held = m;
          end
        end
      end
    end
    r.switch_mode = held;
    r.button_state = btn;
    r.press_change_count = changes;
    r.module_ok_event = mok;
    r.mode_event = ev;
    return r;
  endfunction

  function automatic dir_row_t script_row(logic [2:0] sys, logic v, logic [9:0] s,
                                          logic [15:0] t, bit typed);
    dir_row_t d;
    d.stim = '{sys, v, s, t};
    d.typed = typed;
    d.want = RESET_REPORT;
    return d;
  endfunction

  // Pick a reading inside the window of a class, often at its edges.
  function automatic logic [9:0] ladder_value(class_t c);
    int lo;
    int hi;
    case (c)
      CL_BUTTON: begin lo = 0;   hi = 40;   end
      CL_OFF:    begin lo = 368; hi = 450;  end
      CL_MANUAL: begin lo = 573; hi = 655;  end
      CL_AUTO:   begin lo = 778; hi = 860;  end
      CL_DISC:   begin lo = 982; hi = 1023; end
      default: begin
        case ($urandom_range(0, 3))
          0:       begin lo = 41;  hi = 367; end
          1:       begin lo = 451; hi = 572; end
          2:       begin lo = 656; hi = 777; end
          default: begin lo = 861; hi = 981; end
        endcase
      end
    endcase
    case ($urandom_range(0, 5))
      0:       return 10'(lo);
      1:       return 10'(hi);
      default: return 10'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [15:0] advance_clock();
    if ($urandom_range(0, 63) == 0) tick_clock = 16'($urandom_range(0, 65535));
    else tick_clock = tick_clock + 16'($urandom_range(0, 60));
    return tick_clock;
  endfunction

  // Offer one request, log its report once accepted, then maybe idle.
  task automatic offer(in_item_t it, bit typed, out_item_t want);
    out_item_t got;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict_switch_report(it);
    expected_reports.push_back(typed ? want : got);
    if (gaps_on && !long_hold_req && !long_hold_busy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic set_hold_limit(logic [15:0] v);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hold_limit = v;
  endtask

  task automatic run_random(int n_items, bit press_hold);
    int       counted;
    int       len;
    bit       hold_started;
    class_t   cls;
    in_item_t it;
    counted = 0;
    hold_started = 1'b0;
    while (counted < n_items) begin
      if (press_hold && !hold_started && counted >= n_items / 2) begin
        long_hold_req = 1'b1;
        hold_started = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          // Well-formed run of one class, now and then broken by a failed read.
          case ($urandom_range(0, 7))
            0, 1, 2: cls = CL_BUTTON;
            3:       cls = CL_OFF;
            4:       cls = CL_MANUAL;
            5:       cls = CL_AUTO;
            6:       cls = CL_DISC;
            default: cls = CL_INVALID;
          endcase
          len = $urandom_range(4, 16);
          for (int k = 0; k < len; k++) begin
            it.system_state = ($urandom_range(0, 9) == 0) ? SYS_ACC_ON : SYS_ACTIVE;
            it.sample_valid = ($urandom_range(0, 29) != 0);
            it.ladder_sample = ladder_value(cls);
            it.time_now = advance_clock();
            offer(it, 1'b0, '0);
            counted++;
          end
        end
        7: begin
          // Power cycle: pre-off or inspection ticks, then accessory on.
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++) begin
            it.system_state = ($urandom_range(0, 3) == 0) ? SYS_INSPECT : SYS_PRE_OFF;
            it.sample_valid = 1'b1;
            it.ladder_sample = ladder_value(CL_OFF);
            it.time_now = advance_clock();
            offer(it, 1'b0, '0);
            counted++;
          end
          it.system_state = SYS_ACC_ON;
          it.ladder_sample = ladder_value(CL_AUTO);
          it.time_now = advance_clock();
          offer(it, 1'b0, '0);
          counted++;
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            it.system_state = 3'($urandom_range(0, 7));
            it.sample_valid = 1'($urandom_range(0, 1));
            it.ladder_sample = 10'($urandom_range(0, 1023));
            it.time_now = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : advance_clock();
            offer(it, 1'b0, '0);
            if (it.system_state >= SYS_ACC_ON && it.system_state <= SYS_INSPECT) counted++;
          end
        end
      endcase
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Stimulus and phase control.
  initial begin
    dir_row_t    script [$];
    logic [15:0] limits [6];
    clear_tracking();
    hold_limit = RESET_HOLD_LIMIT;

    script.push_back(script_row(SYS_INACTIVE, 1'b1, 10'd500, 16'd0, 1'b1));
    script.push_back(script_row(SYS_UNDEF, 1'b1, 10'd0, 16'd65535, 1'b1));
    script.push_back(script_row(SYS_INSPECT, 1'b1, 10'd0, 16'd0, 1'b1));
    script.push_back(script_row(SYS_ACTIVE, 1'b0, 10'd1023, 16'd0, 1'b1));
    for (int k = 0; k < 4; k++)
      script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd1023, 16'd10, 1'b1));
    script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd1023, 16'd10, 1'b0));
    for (int k = 0; k < 5; k++)
      script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd0, 16'd100, 1'b0));
    // Elapsed hold equals the limit exactly on the fifth of these.
    for (int k = 0; k < 5; k++)
      script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd40, 16'd400, 1'b0));
    script.push_back(script_row(SYS_PRE_OFF, 1'b1, 10'd450, 16'd401, 1'b0));
    script.push_back(script_row(SYS_ACC_ON, 1'b1, 10'd368, 16'd402, 1'b1));
    script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd41, 16'd403, 1'b0));
    script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd367, 16'd404, 1'b0));
    script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd982, 16'd405, 1'b0));
    script.push_back(script_row(SYS_ACTIVE, 1'b1, 10'd860, 16'd65535, 1'b0));

    limits[0] = 16'd0;
    limits[1] = 16'hFFFF;
    limits[2] = 16'd7;
    limits[3] = 16'($urandom_range(0, 65535));
    limits[4] = 16'd150;
    limits[5] = RESET_HOLD_LIMIT;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer(script[i].stim, script[i].typed, script[i].want);
    in_valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      set_hold_limit(limits[p]);
      run_random(PHASE_ITEMS, p == 2);
      in_valid <= 1'b0;
    end

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_busy = 1'b1;
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_busy = 1'b0;
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Compare each accepted report with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected report, expected none actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        head_report = expected_reports.pop_front();
        check_field("switch_mode", 8'(head_report.switch_mode), 8'(out_data.switch_mode));
        check_field("button_state", 8'(head_report.button_state), 8'(out_data.button_state));
        check_field("press_change_count", head_report.press_change_count,
                    out_data.press_change_count);
        check_field("module_ok_event", 8'(head_report.module_ok_event),
                    8'(out_data.module_ok_event));
        check_field("mode_event", 8'(head_report.mode_event), 8'(out_data.mode_event));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
